>>> hw/rtl/tmf_pkg.sv
// Shared types and constants for the trimmed mean filter.
// Holds the command and status structs that join the controller and the datapath.
// No dependencies.
package tmf_pkg;

    // Fixed widths of the stream payloads
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // Commands from controller to datapath
    typedef struct packed {
        logic insert;    // insert the accepted beat into the sorted cells
        logic sum_clr;   // clear accumulator and step counter
        logic sum_step;  // add the lowest cell and shift the chain down
        logic div_load;  // load magnitude and sign of the sum
        logic div_step;  // multiply the magnitude by the reciprocal of the kept count
        logic out_load;  // capture the saturated mean in the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_last; // the cells hold all but one sample of the window
        logic sum_last;  // current summing step is the final one
    } t_dp_sts;

endpackage

>>> hw/rtl/tmf_ctrl.sv
// Controller for the trimmed mean filter: sequences fill, sum, divide and output.
// Depends on tmf_pkg for the command and status structs.
module tmf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tmf_pkg::t_dp_sts   i_sts,
    output tmf_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == ST_FILL);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == ST_FILL);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Decode commands and next state
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_FILL: begin
                if (w_accept) begin
                    o_cmd.insert = 1'b1;
                    if (i_sts.fill_last) begin
                        o_cmd.sum_clr = 1'b1;
                        n_state       = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_last) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/tmf_datapath.sv
// Datapath for the trimmed mean filter: insertion-sort cell chain, accumulator,
// reciprocal multiply by the kept count, saturation and output register.
// Depends on tmf_pkg for the command and status structs.
module tmf_datapath #(
    parameter int SAMPLE_COUNT = 10,
    parameter int DISCARD      = 2,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tmf_pkg::IN_W-1:0]       i_sample,
    input  tmf_pkg::t_dp_cmd               i_cmd,
    output tmf_pkg::t_dp_sts               o_sts,
    output logic [tmf_pkg::OUT_W-1:0]      o_mean
);

    localparam int N         = SAMPLE_COUNT;
    localparam int SW        = SAMPLE_WIDTH;
    localparam int KEPT      = SAMPLE_COUNT - 2 * DISCARD;
    localparam int DIVISOR   = (KEPT > 0) ? KEPT : 1;
    localparam int SUM_STEPS = (N - DISCARD > 0) ? (N - DISCARD) : 1;
    localparam int CW        = $clog2(N);
    localparam int ACC_W     = SW + $clog2(N) + 1;
    localparam int STEP_W    = (SUM_STEPS > 1) ? $clog2(SUM_STEPS) : 1;
    // Magnitudes at or above CAP saturate for either sign
    localparam int CAP       = 32769 * DIVISOR;
    localparam int QN        = $clog2(CAP);
    localparam int MAG_W     = (ACC_W > QN) ? ACC_W : QN;
    // Reciprocal of the kept count, exact for dividends below 2**QN
    localparam int RL        = $clog2(DIVISOR);
    localparam int RS        = QN + RL;
    localparam int RM_W      = QN + 1;
    localparam int PW        = QN + RM_W;
    localparam longint RM    = ((longint'(1) << RS) + longint'(DIVISOR - 1))
                               / longint'(DIVISOR);
    localparam int Q_W       = 17;

    logic signed [SW-1:0]    r_cell [N];
    logic signed [SW-1:0]    n_cell [N];
    logic [N-1:0]            w_gt;
    logic signed [SW-1:0]    w_x;
    logic [CW-1:0]           r_fill;
    logic signed [ACC_W-1:0] r_acc;
    logic [STEP_W-1:0]       r_step;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic                    w_capped;
    logic [PW-1:0]           w_prod;
    logic [Q_W-1:0]          r_quo;
    logic [tmf_pkg::OUT_W-1:0] w_sat;
    logic [tmf_pkg::OUT_W-1:0] r_mean;

    // Read the beat as SAMPLE_WIDTH bits
    generate
        if (SW <= tmf_pkg::IN_W) begin : g_narrow
            assign w_x = i_sample[SW-1:0];
        end else begin : g_wide
            assign w_x = {{(SW - tmf_pkg::IN_W){1'b0}}, i_sample};
        end
    endgenerate

    // Cells above the new sample, empty cells count as above
    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_gt[k] = (r_fill <= CW'(k)) || (r_cell[k] > w_x);
        end
    end

    // Next cell values: insert or shift down
    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_cell[k] = r_cell[k];
            if (i_cmd.insert) begin
                if (w_gt[k]) begin
                    if (k == 0) begin
                        n_cell[k] = w_x;
                    end else if (!w_gt[(k > 0) ? k - 1 : 0]) begin
                        n_cell[k] = w_x;
                    end else begin
                        n_cell[k] = r_cell[(k > 0) ? k - 1 : 0];
                    end
                end
            end else if (i_cmd.sum_step) begin
                if (k < N - 1) begin
                    n_cell[k] = r_cell[(k < N - 1) ? k + 1 : k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            r_cell[k] <= n_cell[k];
        end
    end

    // Fill count of the current window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.insert) begin
            if (o_sts.fill_last) begin
                r_fill <= '0;
            end else begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    // Divide the magnitude by the kept count: cap check, then reciprocal multiply
    assign w_capped = ({{(64 - MAG_W){1'b0}}, r_mag} >= 64'(CAP));
    assign w_prod   = {{RM_W{1'b0}}, r_mag[QN-1:0]} * PW'(RM);

    // Accumulate the middle of the sorted chain, then divide the magnitude
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) begin
            r_acc  <= '0;
            r_step <= '0;
        end else if (i_cmd.sum_step) begin
            if ({{(32 - STEP_W){1'b0}}, r_step} >= 32'(DISCARD)) begin
                r_acc <= r_acc + ACC_W'(r_cell[0]);
            end
            r_step <= r_step + STEP_W'(1);
        end else if (i_cmd.div_load) begin
            r_neg  <= r_acc[ACC_W-1];
            r_mag  <= r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'($unsigned(r_acc));
        end else if (i_cmd.div_step) begin
            r_quo  <= w_capped ? Q_W'(32769) : Q_W'(w_prod[PW-1:RS]);
        end
    end

    // Saturate the signed quotient to the output range
    always_comb begin
        if (KEPT <= 0) begin
            w_sat = '0;
        end else if (!r_neg) begin
            w_sat = (r_quo > Q_W'(32767)) ? 16'h7FFF : r_quo[15:0];
        end else begin
            w_sat = (r_quo > Q_W'(32768)) ? 16'h8000 : (~r_quo[15:0] + 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean <= w_sat;
        end
    end

    assign o_mean          = r_mean;
    assign o_sts.fill_last = (r_fill == CW'(N - 1));
    assign o_sts.sum_last  = (r_step == STEP_W'(SUM_STEPS - 1));

endmodule

>>> hw/rtl/trimmed_mean_filter.sv
// Trimmed mean filter: takes one sample beat per cycle until SAMPLE_COUNT are held.
// After the last beat of a window the filter is closed to input while it shifts the
// cell chain down once per step, dropping the lowest DISCARD cells and summing the
// kept ones, then loads the magnitude, does the reciprocal multiply and loads the
// output register, waiting first while an earlier mean is still unread.
// Synchronous active-low reset clears the controller, fill count and output valid.
module trimmed_mean_filter #(
    parameter int SAMPLE_COUNT = 10,
    parameter int DISCARD      = 2,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [tmf_pkg::IN_W-1:0]   s_axis_tdata,   // [15:0] sample
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [tmf_pkg::OUT_W-1:0]  m_axis_tdata    // [15:0] mean
);

    tmf_pkg::t_dp_cmd w_cmd;
    tmf_pkg::t_dp_sts w_sts;

    tmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tmf_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .DISCARD      (DISCARD),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_mean   (m_axis_tdata)
    );

endmodule
